### rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the sinusoid generator (pmsg_back).
// No dependencies; each macro expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMSG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PMSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMSG_ASSERT(lbl, clk, rstn, prop, msg)
`define PMSG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/pmsg_pkg.sv
// Package of the pitch-mark sinusoid generator: widths, codes, the job type
// and the quarter-wave sine table builder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmsg_pkg;

  localparam int MAX_PERIOD_DEF = 511;
  localparam int LANES_DEF      = 8;
  localparam int JOBQ_DEPTH     = 2;
  localparam int LEN_W          = 9;
  localparam int NUM_SLOTS      = 8;
  localparam int SAMP_W         = 16;
  localparam int CNT_W          = 4;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_NEG  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] wave_len;  // closed span, sinusoid or zeros
    logic             wave;      // closed span carries a sinusoid
    logic             neg;       // sinusoid is negated
    logic [LEN_W-1:0] zero_len;  // trailing zeros (overflow or end of stream)
    logic             ovf;       // voiced span overflow
    logic             mode;      // 0 sine, 1 cosine
  } pmsg_job_t;

  typedef logic signed [SAMP_W-1:0] qtab_t [0:1024];

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Shift-subtract division, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], n[k]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767*sin(pi*p/2048)) with Q2.62 arithmetic.
  function automatic logic signed [SAMP_W-1:0] quarter_value(input int p);
    logic [63:0] pp;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] d;
    pp = 64'(p);
    x  = (PI_Q62 >> 11) * pp + (((PI_Q62 & 64'd2047) * pp) >> 11);
    x2 = mul_q62(x, x);
    t  = ONE_Q62;
    for (int j = 15; j >= 1; j--) begin
      d = 64'(2 * j) * 64'(2 * j + 1);
      t = ONE_Q62 - udiv64(mul_q62(x2, t), d);
    end
    s = mul_q62(x, t);
    v = ((s >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
    if (v > 64'd32767) v = 64'd32767;
    return v[SAMP_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int p = 0; p <= 1024; p++) tab[p] = quarter_value(p);
    return tab;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pmsg_front.sv
// Front end: accepts input items, tracks voiced regions and span lengths,
// and turns each item into a job. Depends on pmsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmsg_front #(
  parameter int MAX_PERIOD = pmsg_pkg::MAX_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          mark_kind,
  input  logic                voiced,
  input  logic                end_of_stream,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output pmsg_pkg::pmsg_job_t job,
  output logic                job_push
);
  import pmsg_pkg::*;

  logic             started_r, started_nxt;
  logic             region_r, region_nxt;
  logic             neg_r, neg_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             mode_r;

  logic             has_mark;
  logic             close;
  logic             wave;
  logic             region_upd;
  logic             neg_upd;
  logic [LEN_W-1:0] s1;
  logic             ovf_hit;
  logic             ovf;

  always_comb begin
    has_mark   = (mark_kind != MARK_NONE);
    close      = 1'b0;
    wave       = 1'b0;
    region_upd = region_r;
    neg_upd    = neg_r;
    s1         = len_r + LEN_W'(1);
    if (!started_r) begin
      region_upd = has_mark;
      neg_upd    = (mark_kind == MARK_NEG);
      s1         = LEN_W'(1);
    end else begin
      if (region_r) begin
        if (has_mark) begin
          close = 1'b1;
          wave  = 1'b1;
        end else if (!voiced) begin
          close      = 1'b1;
          wave       = 1'b1;
          region_upd = 1'b0;
        end
      end else if (has_mark) begin
        close      = 1'b1;
        region_upd = 1'b1;
      end
      if (close) begin
        s1      = LEN_W'(1);
        neg_upd = (mark_kind == MARK_NEG);
      end
    end
    ovf_hit = (s1 >= LEN_W'(MAX_PERIOD));
    ovf     = ovf_hit && region_upd;

    started_nxt = 1'b1;
    region_nxt  = region_upd;
    neg_nxt     = neg_upd;
    len_nxt     = ovf_hit ? '0 : s1;
    if (end_of_stream || ovf) begin
      started_nxt = 1'b0;
      region_nxt  = 1'b0;
      neg_nxt     = 1'b0;
      len_nxt     = '0;
    end

    job.wave_len = close ? len_r : '0;
    job.wave     = wave;
    job.neg      = neg_r;
    job.zero_len = (ovf_hit || end_of_stream) ? s1 : '0;
    job.ovf      = ovf;
    job.mode     = mode_r;
    job_push     = accept && ((job.wave_len != '0) || (job.zero_len != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      region_r  <= 1'b0;
      neg_r     <= 1'b0;
      len_r     <= '0;
      mode_r    <= 1'b0;
    end else begin
      if (accept) begin
        started_r <= started_nxt;
        region_r  <= region_nxt;
        neg_r     <= neg_nxt;
        len_r     <= len_nxt;
      end
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/core/pmsg_jobq.sv
// Short job queue between the front end and the generator.
// Depends on pmsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmsg_jobq #(
  parameter int DEPTH = pmsg_pkg::JOBQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pmsg_pkg::pmsg_job_t wdata,
  input  logic                pop,
  output pmsg_pkg::pmsg_job_t rdata,
  output logic                full,
  output logic                empty
);
  import pmsg_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pmsg_job_t       mem_r [0:DEPTH-1];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PtrW'(DEPTH - 1)) ? '0 : wptr_r + PtrW'(1);
      if (do_pop)  rptr_r <= (rptr_r == PtrW'(DEPTH - 1)) ? '0 : rptr_r + PtrW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CntW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CntW'(1);
    end
  end

endmodule
`default_nettype wire

### rtl/core/pmsg_back.sv
// Generator: turns jobs into sinusoid or zero samples, packs them into
// results and holds the result register. Depends on pmsg_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pmsg_back #(
  parameter int LANES = pmsg_pkg::LANES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pmsg_pkg::pmsg_job_t        job,
  input  logic                       job_valid,
  output logic                       job_pop,
  output logic signed [15:0]         out_samp [0:pmsg_pkg::NUM_SLOTS-1],
  output logic [pmsg_pkg::CNT_W-1:0] out_cnt,
  output logic                       out_last,
  output logic                       out_ovf,
  output logic                       out_empty,
  input  logic                       out_pop
);
  import pmsg_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_GEN_A = 2'd2;
  localparam logic [1:0] ST_GEN_B = 2'd3;

  localparam qtab_t QTab = build_qtab();

  logic [1:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  wlen_r;
  logic              wave_r, neg_r, ovf_r, mode_r;
  logic [LEN_W:0]    total_r;
  logic [LEN_W:0]    done_r, done_nxt;
  logic [12:0]       dq_r;
  logic [LEN_W:0]    rem_r;
  logic [3:0]        div_cnt_r;
  logic [12:0]       ph_q_r;
  logic [LEN_W-1:0]  ph_r_r;
  logic signed [15:0] rom_r;
  logic              sgn_r, zero_r;
  logic signed [15:0] lane_r [0:NUM_SLOTS-1];
  logic [2:0]        lane_cnt_r;

  logic              out_valid_r;
  logic signed [15:0] out_samp_r [0:NUM_SLOTS-1];
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r, out_ovf_r;

  logic              out_free;
  logic [LEN_W:0]    rem_sh;
  logic              rem_ge;
  logic [11:0]       phase;
  logic [10:0]       addr;
  logic signed [15:0] val;
  logic [CNT_W-1:0]  new_cnt;
  logic              last;
  logic              flush;
  logic              emit;
  logic [LEN_W:0]    ph_sum;

  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    rem_sh  = {rem_r[LEN_W-1:0], (div_cnt_r == 4'd0)};
    rem_ge  = (rem_sh >= {1'b0, wlen_r});
    phase   = ph_q_r[11:0] + (mode_r ? 12'd1024 : 12'd0);
    addr    = phase[10] ? (11'd1024 - {1'b0, phase[9:0]}) : {1'b0, phase[9:0]};
    val     = zero_r ? 16'sd0 : (sgn_r ? -rom_r : rom_r);
    new_cnt = {1'b0, lane_cnt_r} + CNT_W'(1);
    done_nxt = done_r + (LEN_W+1)'(1);
    last    = (done_nxt == total_r);
    flush   = last || (new_cnt == CNT_W'(LANES));
    emit    = (state_r == ST_GEN_B) && flush && out_free;
    ph_sum  = {1'b0, ph_r_r} + rem_r;
    job_pop = (state_r == ST_IDLE) && job_valid;

    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) state_nxt = (job.wave && job.wave_len != '0) ? ST_DIV : ST_GEN_A;
      end
      ST_DIV: begin
        if (div_cnt_r == 4'd12) state_nxt = ST_GEN_A;
      end
      ST_GEN_A: state_nxt = ST_GEN_B;
      ST_GEN_B: begin
        if (!flush || out_free) state_nxt = last ? ST_IDLE : ST_GEN_A;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        wlen_r    <= job.wave_len;
        wave_r    <= job.wave;
        neg_r     <= job.neg;
        ovf_r     <= job.ovf;
        mode_r    <= job.mode;
        total_r   <= {1'b0, job.wave_len} + {1'b0, job.zero_len};
        done_r    <= '0;
        dq_r      <= '0;
        rem_r     <= '0;
        div_cnt_r <= '0;
        ph_q_r    <= '0;
        ph_r_r    <= '0;
      end
      ST_DIV: begin
        // One quotient bit of 4096 / span length per cycle.
        rem_r     <= rem_ge ? (rem_sh - {1'b0, wlen_r}) : rem_sh;
        dq_r      <= {dq_r[11:0], rem_ge};
        div_cnt_r <= div_cnt_r + 4'd1;
      end
      ST_GEN_A: begin
        rom_r  <= QTab[addr];
        sgn_r  <= phase[11] ^ neg_r;
        zero_r <= !(wave_r && (done_r < {1'b0, wlen_r}));
      end
      ST_GEN_B: begin
        if (!flush || out_free) begin
          lane_r[lane_cnt_r] <= val;
          done_r <= done_nxt;
          // Phase steps by 4096 / length; the remainder carries a unit.
          if (ph_sum >= {1'b0, wlen_r}) begin
            ph_r_r <= LEN_W'(ph_sum - {1'b0, wlen_r});
            ph_q_r <= ph_q_r + dq_r + 13'd1;
          end else begin
            ph_r_r <= ph_sum[LEN_W-1:0];
            ph_q_r <= ph_q_r + dq_r;
          end
        end
      end
      default: ;
    endcase
    if (emit) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (CNT_W'(j) >= new_cnt)               out_samp_r[j] <= '0;
        else if (3'(j) == lane_cnt_r)           out_samp_r[j] <= val;
        else                                    out_samp_r[j] <= lane_r[j];
      end
      out_cnt_r  <= new_cnt;
      out_last_r <= last;
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_GEN_B && (!flush || out_free))
        lane_cnt_r <= flush ? '0 : lane_cnt_r + 3'd1;
      if (emit)         out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  assign out_samp  = out_samp_r;
  assign out_cnt   = out_cnt_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;
  assign out_empty = !out_valid_r;

  `PMSG_ASSERT(a_lane_cnt, clk, rst_n, CNT_W'(lane_cnt_r) < CNT_W'(LANES), "lane count overrun")
  `PMSG_ASSERT(a_done_lt_total, clk, rst_n, (state_r != ST_IDLE) |-> (done_r < total_r), "sample count passed span total")
  `PMSG_ASSERT(a_stall_holds, clk, rst_n, (state_r == ST_GEN_B && flush && !out_free) |=> (state_r == ST_GEN_B && $stable(done_r)), "stalled emit did not hold")
  `PMSG_ASSERT(a_div_wave, clk, rst_n, (state_r == ST_DIV) |-> (wave_r && wlen_r != '0), "divide started without a sinusoid span")

endmodule
`default_nettype wire

### rtl/core/pitch_mark_sinusoid_generator.sv
// Top level of the pitch-mark sinusoid generator: front end, job queue and
// generator. Depends on pmsg_pkg, pmsg_front, pmsg_jobq, pmsg_back.
`timescale 1ns / 1ps
`default_nettype none
// The block reads one sample per item (pitch mark kind, voiced flag, end of
// stream) and writes the resulting waveform as results of up to LANES Q1.15
// samples each. Every span between pitch marks in a voiced region becomes one
// period of a sine or cosine (cfg_output_mode), negated when the opening mark
// was negative; unvoiced spans, spans left open at end of stream and voiced
// spans that reach MAX_PERIOD come out as zeros, the last with span_overflow.
// The front end takes an item in any cycle in which its two-entry job queue
// has room. The generator works through one job at a time: after it takes the
// job, a sinusoid span passes through a bit-serial divider that finds 4096
// divided by the span length, then every output sample takes two steps (sine
// table read, then packing). A result that is not popped stalls the
// generator; once the job queue has also filled, full rises and the input is
// held off until results are popped again. cfg_output_mode may only be
// written while the block is idle. No clearing pass follows reset.

module pitch_mark_sinusoid_generator #(
  parameter int MAX_PERIOD = pmsg_pkg::MAX_PERIOD_DEF,
  parameter int LANES      = pmsg_pkg::LANES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_mark_kind,
  input  logic                       in_voiced,
  input  logic                       in_end_of_stream,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [15:0]         out_sample_0,
  output logic signed [15:0]         out_sample_1,
  output logic signed [15:0]         out_sample_2,
  output logic signed [15:0]         out_sample_3,
  output logic signed [15:0]         out_sample_4,
  output logic signed [15:0]         out_sample_5,
  output logic signed [15:0]         out_sample_6,
  output logic signed [15:0]         out_sample_7,
  output logic [pmsg_pkg::CNT_W-1:0] out_valid_count,
  output logic                       out_last_of_run,
  output logic                       out_span_overflow,
  input  logic                       cfg_we,
  input  logic                       cfg_output_mode
);
  import pmsg_pkg::*;

  pmsg_job_t         fe_job, q_job;
  logic              fe_push;
  logic              q_empty, q_pop;
  logic              accept;
  logic signed [15:0] samp [0:NUM_SLOTS-1];

  // An item is taken whenever the job queue has room.
  assign accept = push && !full;

  pmsg_front #(.MAX_PERIOD(MAX_PERIOD)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .mark_kind     (in_mark_kind),
    .voiced        (in_voiced),
    .end_of_stream (in_end_of_stream),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_output_mode),
    .job           (fe_job),
    .job_push      (fe_push)
  );

  // Items that produce no samples push nothing, so the queue full flag
  // alone throttles the input.
  pmsg_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata (fe_job),
    .pop   (q_pop),
    .rdata (q_job),
    .full  (full),
    .empty (q_empty)
  );

  pmsg_back #(.LANES(LANES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_job),
    .job_valid (!q_empty),
    .job_pop   (q_pop),
    .out_samp  (samp),
    .out_cnt   (out_valid_count),
    .out_last  (out_last_of_run),
    .out_ovf   (out_span_overflow),
    .out_empty (empty),
    .out_pop   (pop)
  );

  assign out_sample_0 = samp[0];
  assign out_sample_1 = samp[1];
  assign out_sample_2 = samp[2];
  assign out_sample_3 = samp[3];
  assign out_sample_4 = samp[4];
  assign out_sample_5 = samp[5];
  assign out_sample_6 = samp[6];
  assign out_sample_7 = samp[7];

endmodule
`default_nettype wire
